/* design/jbt_pkg.sv */
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, constants and byte-class functions of the JSON byte
// tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

   // Default longest stored token text, in bytes.
   localparam int TEXT_MAX_DEF = 63;
   // Widest text length field that any allowed TEXT_MAX needs.
   localparam int LEN_W_MAX = 8;
   localparam int LINE_W = 24;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;
   // Result queue depth; a power of two so that pointers wrap on their own.
   localparam int QUEUE_DEPTH = 4;
   localparam int KW_COUNT = 3;

   // Result kinds.
   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_TOKEN = 1'b1;

   // Keyword candidates.
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;

   typedef enum logic [3:0] {
      TOK_UNKNOWN      = 4'd0,
      TOK_LBRACKET     = 4'd1,
      TOK_RBRACKET     = 4'd2,
      TOK_LBRACE       = 4'd3,
      TOK_RBRACE       = 4'd4,
      TOK_BOOLEAN      = 4'd5,
      TOK_NULL         = 4'd6,
      TOK_NUMBER       = 4'd7,
      TOK_STRING       = 4'd8,
      TOK_COLON        = 4'd9,
      TOK_COMMA        = 4'd10,
      TOK_END          = 4'd11,
      TOK_UNTERMINATED = 4'd12
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_STRING,
      MODE_WORD,
      MODE_HALTED
   } lex_mode_type;

   // One result word as it sits in the result queue.
   typedef struct packed {
      logic                  result_kind;
      token_kind_type        token_type;
      logic [7:0]            text_byte;
      logic [LEN_W_MAX-1:0]  text_length;
      logic signed [31:0]    number_value;
      logic                  number_clipped;
      logic                  bool_value;
      logic [LINE_W-1:0]     line_number;
      logic                  last;
   } result_type;

   // Results of one processed input word, in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

   // Space, tab, newline, vertical tab, form feed or carriage return.
   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   // Single-byte punctuation; anything else decodes as unknown.
   function automatic token_kind_type single_token(input logic [7:0] b);
      token_kind_type kind;
      unique case (b)
         CHAR_LBRACKET: kind = TOK_LBRACKET;
         CHAR_RBRACKET: kind = TOK_RBRACKET;
         CHAR_LBRACE:   kind = TOK_LBRACE;
         CHAR_RBRACE:   kind = TOK_RBRACE;
         CHAR_COLON:    kind = TOK_COLON;
         CHAR_COMMA:    kind = TOK_COMMA;
         default:       kind = TOK_UNKNOWN;
      endcase
      return kind;
   endfunction

   // Keyword spelling table.
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         KW_TRUE: begin
            case (pos)
               3'd0:    c = 8'h74;   // t
               3'd1:    c = 8'h72;   // r
               3'd2:    c = 8'h75;   // u
               3'd3:    c = 8'h65;   // e
               default: c = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (pos)
               3'd0:    c = 8'h66;   // f
               3'd1:    c = 8'h61;   // a
               3'd2:    c = 8'h6C;   // l
               3'd3:    c = 8'h73;   // s
               3'd4:    c = 8'h65;   // e
               default: c = 8'h00;
            endcase
         end
         KW_NULL: begin
            case (pos)
               3'd0:    c = 8'h6E;   // n
               3'd1:    c = 8'h75;   // u
               3'd2:    c = 8'h6C;   // l
               3'd3:    c = 8'h6C;   // l
               default: c = 8'h00;
            endcase
         end
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] kw_length(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         KW_FALSE: len = 3'd5;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

/* design/jbt_if.sv */
// ----------------------------------------------------------------------------
// jbt_req_if / jbt_rsp_if
// Valid/ready channels of the JSON byte tokenizer: text bytes in, result
// words out.
// ----------------------------------------------------------------------------
interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jbt_rsp_if import jbt_pkg::*; #(
   parameter int LEN_W = $clog2(TEXT_MAX_DEF + 1)
);
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [3:0]         token_type;
   logic [7:0]         text_byte;
   logic [LEN_W-1:0]   text_length;
   logic signed [31:0] number_value;
   logic               number_clipped;
   logic               bool_value;
   logic [LINE_W-1:0]  line_number;
   logic               last;

   modport source (
      output valid, output result_kind, output token_type, output text_byte,
      output text_length, output number_value, output number_clipped,
      output bool_value, output line_number, output last, input ready
   );
   modport sink (
      input valid, input result_kind, input token_type, input text_byte,
      input text_length, input number_value, input number_clipped,
      input bool_value, input line_number, input last, output ready
   );
endinterface

/* design/json_byte_tokenizer.sv */
// A word accepted is held in the input register and lexed from there once
// the result queue has room; its results are written into the four-entry
// result queue, whose head drives the result channel. Throughput: one input
// word per cycle while the queue has room; results leave one at a time.
// Reset is synchronous: line 1, no token open.
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON lexer: input register, lexer step logic and result queue.
// ----------------------------------------------------------------------------
module json_byte_tokenizer import jbt_pkg::*; #(
   parameter int TEXT_MAX = TEXT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   jbt_req_if.sink     req_chan,
   jbt_rsp_if.source   rsp_chan
);

   localparam int LEN_W = $clog2(TEXT_MAX + 1);

   logic         item_valid_ff, item_valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         eoi_ff, eoi_in;
   logic         queue_room, step_fire, req_take;
   logic         head_valid;
   step_out_type step_out;
   result_type   head;

   // Input handshake: the held word moves on whenever the queue has room.
   assign step_fire      = item_valid_ff && queue_room;
   assign req_chan.ready = !item_valid_ff || step_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin : input_next
      item_valid_in = item_valid_ff;
      byte_in       = byte_ff;
      eoi_in        = eoi_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
         byte_in       = req_chan.data_byte;
         eoi_in        = req_chan.end_of_input;
      end else if (step_fire) begin
         item_valid_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eoi_ff  <= eoi_in;
   end

   jbt_lexer #(
      .TEXT_MAX (TEXT_MAX)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step_fire    (step_fire),
      .data_byte    (byte_ff),
      .end_of_input (eoi_ff),
      .step_out     (step_out)
   );

   jbt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_out),
      .pop       (rsp_chan.ready),
      .room      (queue_room),
      .not_empty (head_valid),
      .head      (head)
   );

   // Result channel driven from the queue head.
   assign rsp_chan.valid          = head_valid;
   assign rsp_chan.result_kind    = head.result_kind;
   assign rsp_chan.token_type     = 4'(head.token_type);
   assign rsp_chan.text_byte      = head.text_byte;
   assign rsp_chan.text_length    = head.text_length[LEN_W-1:0];
   assign rsp_chan.number_value   = head.number_value;
   assign rsp_chan.number_clipped = head.number_clipped;
   assign rsp_chan.bool_value     = head.bool_value;
   assign rsp_chan.line_number    = head.line_number;
   assign rsp_chan.last           = head.last;

endmodule

/* design/jbt_lexer.sv */
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state and the single-pass step logic: from the registered input word
// and the current state it forms up to two result words and the next state.
// ----------------------------------------------------------------------------
module jbt_lexer import jbt_pkg::*; #(
   parameter int TEXT_MAX = TEXT_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_fire,
   input  logic [7:0]   data_byte,
   input  logic         end_of_input,
   output step_out_type step_out
);

   localparam int LEN_W = $clog2(TEXT_MAX + 1);
   localparam logic [LEN_W-1:0] TEXT_LIMIT = LEN_W'(TEXT_MAX);
   localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

   lex_mode_type      mode_ff, mode_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [LEN_W-1:0]  text_count_ff, text_count_in;
   logic [31:0]       magnitude_ff, magnitude_in;
   logic              negative_ff, negative_in;
   logic              overflow_ff, overflow_in;
   logic [2:0]        kw_match_ff, kw_match_in;
   logic [2:0]        kw_pos_ff, kw_pos_in;

   logic              byte_ws, byte_digit, byte_minus, byte_quote, byte_newline;
   logic              byte_single;
   token_kind_type    single_kind;

   logic              cont, fin_valid, tail_go, tail_valid, store_ok;

   logic [35:0]       times_ten;
   logic [31:0]       limit;
   logic              num_over;
   logic [31:0]       digit_mag;
   logic              digit_ovf;

   logic [2:0]        trk_match_src, trk_pos_src, trk_match, trk_pos;

   result_type        rec_base, rec_store, rec_fin, rec_tail;

   // Byte classes of the current input word.
   assign byte_ws      = is_space(data_byte);
   assign byte_digit   = is_digit(data_byte);
   assign byte_minus   = (data_byte == CHAR_MINUS);
   assign byte_quote   = (data_byte == CHAR_QUOTE);
   assign byte_newline = (data_byte == CHAR_NEWLINE);
   assign single_kind  = single_token(data_byte);
   assign byte_single  = (single_kind != TOK_UNKNOWN);
   assign store_ok     = (text_count_ff < TEXT_LIMIT);

   // Decide whether the byte continues the token, finishes it, and whether it
   // is then handled as a byte between tokens.
   always_comb begin : step_decode
      cont      = 1'b0;
      fin_valid = 1'b0;
      tail_go   = 1'b0;
      unique case (mode_ff)
         MODE_IDLE: tail_go = 1'b1;
         MODE_NUMBER: begin
            cont      = !end_of_input && byte_digit;
            fin_valid = !cont;
            tail_go   = !cont;
         end
         MODE_WORD: begin
            cont      = !(end_of_input || byte_ws || byte_single);
            fin_valid = !cont;
            tail_go   = !cont;
         end
         MODE_STRING: begin
            cont      = !end_of_input && !byte_quote && !byte_newline;
            fin_valid = !cont;
            tail_go   = !end_of_input && byte_newline;
         end
         default: begin
            cont = 1'b0;
         end
      endcase
   end

   // Decimal accumulate with clipping at the signed 32-bit limit.
   assign limit     = negative_ff ? LIMIT_NEG : LIMIT_POS;
   assign times_ten = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0}
                    + {32'd0, data_byte[3:0]};
   assign num_over  = (times_ten > {4'd0, limit});
   assign digit_mag = overflow_ff ? magnitude_ff : (num_over ? limit : times_ten[31:0]);
   assign digit_ovf = overflow_ff | num_over;

   // Keyword tracking: a word that starts here begins with all candidates.
   always_comb begin : keyword_track
      trk_match_src = (mode_ff == MODE_WORD) ? kw_match_ff : 3'b111;
      trk_pos_src   = (mode_ff == MODE_WORD) ? kw_pos_ff : 3'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         trk_match[k] = trk_match_src[k] && (trk_pos_src < kw_length(2'(k)))
                      && (kw_char(2'(k), trk_pos_src) == data_byte);
      end
      trk_pos = (trk_pos_src == 3'd7) ? trk_pos_src : trk_pos_src + 3'd1;
   end

   // Candidate result words.
   always_comb begin : build_records
      rec_base             = '0;
      rec_base.token_type  = TOK_UNKNOWN;
      rec_base.line_number = line_ff;

      // Text byte of a token in progress.
      rec_store             = rec_base;
      rec_store.result_kind = KIND_TEXT;
      rec_store.text_byte   = data_byte;
      if (mode_ff == MODE_NUMBER) begin
         rec_store.token_type = TOK_NUMBER;
      end else if (mode_ff == MODE_STRING) begin
         rec_store.token_type = TOK_STRING;
      end

      // Completed token that the byte ends.
      rec_fin             = rec_base;
      rec_fin.result_kind = KIND_TOKEN;
      rec_fin.text_length = LEN_W_MAX'(text_count_ff);
      case (mode_ff)
         MODE_NUMBER: begin
            // A lone minus has no digits and is not a number.
            if (!(negative_ff && (text_count_ff == LEN_W'(1)))) begin
               rec_fin.token_type     = TOK_NUMBER;
               rec_fin.number_value   = negative_ff ? (~magnitude_ff + 32'd1)
                                                    : magnitude_ff;
               rec_fin.number_clipped = overflow_ff;
            end
         end
         MODE_WORD: begin
            if (kw_match_ff[KW_TRUE] && (kw_pos_ff == 3'd4)) begin
               rec_fin.token_type = TOK_BOOLEAN;
               rec_fin.bool_value = 1'b1;
            end else if (kw_match_ff[KW_FALSE] && (kw_pos_ff == 3'd5)) begin
               rec_fin.token_type = TOK_BOOLEAN;
            end else if (kw_match_ff[KW_NULL] && (kw_pos_ff == 3'd4)) begin
               rec_fin.token_type = TOK_NULL;
            end
         end
         MODE_STRING: begin
            rec_fin.token_type = end_of_input ? TOK_UNTERMINATED : TOK_STRING;
         end
         default: begin
            rec_fin.token_type = TOK_UNKNOWN;
         end
      endcase

      // Result of the byte handled between tokens.
      rec_tail   = rec_base;
      tail_valid = 1'b1;
      if (end_of_input) begin
         rec_tail.result_kind = KIND_TOKEN;
         rec_tail.token_type  = TOK_END;
      end else if (byte_ws || byte_quote) begin
         tail_valid = 1'b0;
      end else if (byte_single) begin
         rec_tail.result_kind = KIND_TOKEN;
         rec_tail.token_type  = single_kind;
         rec_tail.text_byte   = data_byte;
         rec_tail.text_length = LEN_W_MAX'(1);
      end else begin
         rec_tail.result_kind = KIND_TEXT;
         rec_tail.token_type  = (byte_digit || byte_minus) ? TOK_NUMBER : TOK_UNKNOWN;
         rec_tail.text_byte   = data_byte;
      end
   end

   // Order the results of this step and mark the last one.
   always_comb begin : assemble
      step_out.count  = 2'd0;
      step_out.first  = rec_base;
      step_out.second = rec_base;
      if (cont) begin
         step_out.first      = rec_store;
         step_out.first.last = 1'b1;
         step_out.count      = store_ok ? 2'd1 : 2'd0;
      end else if (fin_valid && tail_go && tail_valid) begin
         step_out.first       = rec_fin;
         step_out.second      = rec_tail;
         step_out.second.last = 1'b1;
         step_out.count       = 2'd2;
      end else if (fin_valid) begin
         step_out.first      = rec_fin;
         step_out.first.last = 1'b1;
         step_out.count      = 2'd1;
      end else if (tail_go && tail_valid) begin
         step_out.first      = rec_tail;
         step_out.first.last = 1'b1;
         step_out.count      = 2'd1;
      end
      if (!step_fire) begin
         step_out.count = 2'd0;
      end
   end

   // Next lexer mode.
   always_comb begin : next_mode
      mode_in = mode_ff;
      if (step_fire && !cont) begin
         if ((mode_ff == MODE_STRING) && !tail_go) begin
            mode_in = end_of_input ? MODE_HALTED : MODE_IDLE;
         end else if (tail_go) begin
            if (end_of_input || byte_ws || byte_single) begin
               mode_in = MODE_IDLE;
            end else if (byte_digit || byte_minus) begin
               mode_in = MODE_NUMBER;
            end else if (byte_quote) begin
               mode_in = MODE_STRING;
            end else begin
               mode_in = MODE_WORD;
            end
         end
      end
   end

   // Next token data and line count.
   always_comb begin : next_data
      line_in       = line_ff;
      text_count_in = text_count_ff;
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      overflow_in   = overflow_ff;
      kw_match_in   = kw_match_ff;
      kw_pos_in     = kw_pos_ff;
      if (step_fire) begin
         if (cont) begin
            if (store_ok) begin
               text_count_in = text_count_ff + LEN_W'(1);
            end
            if (mode_ff == MODE_NUMBER) begin
               magnitude_in = digit_mag;
               overflow_in  = digit_ovf;
            end
            if (mode_ff == MODE_WORD) begin
               kw_match_in = trk_match;
               kw_pos_in   = trk_pos;
            end
         end else if (tail_go && !end_of_input) begin
            if (byte_newline && (line_ff != LINE_MAX)) begin
               line_in = line_ff + LINE_W'(1);
            end
            if (byte_ws || byte_single) begin
               text_count_in = text_count_ff;
            end else if (byte_digit || byte_minus) begin
               text_count_in = LEN_W'(1);
               magnitude_in  = byte_digit ? {28'd0, data_byte[3:0]} : 32'd0;
               overflow_in   = 1'b0;
               negative_in   = byte_minus;
            end else if (byte_quote) begin
               text_count_in = '0;
            end else begin
               text_count_in = LEN_W'(1);
               kw_match_in   = trk_match;
               kw_pos_in     = trk_pos;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         line_ff       <= LINE_W'(1);
         text_count_ff <= '0;
         magnitude_ff  <= '0;
         negative_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         kw_match_ff   <= 3'b111;
         kw_pos_ff     <= 3'd0;
      end else begin
         mode_ff       <= mode_in;
         line_ff       <= line_in;
         text_count_ff <= text_count_in;
         magnitude_ff  <= magnitude_in;
         negative_ff   <= negative_in;
         overflow_ff   <= overflow_in;
         kw_match_ff   <= kw_match_in;
         kw_pos_ff     <= kw_pos_in;
      end
   end

endmodule

/* design/jbt_rsp_queue.sv */
// ----------------------------------------------------------------------------
// jbt_rsp_queue
// Small result queue: takes up to two result words per cycle from the lexer
// and hands out one per cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module jbt_rsp_queue import jbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  step_out_type push,
   input  logic         pop,
   output logic         room,
   output logic         not_empty,
   output result_type   head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   result_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   // Status toward the lexer and the result channel.
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign do_pop    = pop && not_empty;
   assign head      = entries_ff[rd_ptr_ff];

   // Pointer and fill updates.
   always_comb begin : next_pointers
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(do_pop);
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON byte tokenizer. Text words are pushed
// through the request channel under four flow-control phases. A lexer
// predictor in the bench computes every text and token result word. A
// checker compares each delivered result word, field by field, with the
// oldest prediction. The run ends with an open string cut off by end of
// input, which halts the block for the rest of the run.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import jbt_pkg::*;

   localparam int unsigned TEXT_CAP     = 63;
   localparam logic [23:0] LINE_TOP     = 24'hFFFFFF;
   localparam int          RUN_LIMIT    = 400000;
   localparam int          DRAIN_CYCLES = 12;
   localparam int          PHASE_WORDS  = 380;
   localparam int          MAX_REPORTS  = 40;
   localparam logic [7:0]  CHAR_VTAB    = 8'h0B;
   localparam logic [7:0]  CHAR_FFEED   = 8'h0C;

   // One predicted or observed result word.
   typedef struct {
      logic           kind;
      token_kind_type ttype;
      logic [7:0]     tbyte;
      logic [5:0]     tlen;
      logic [31:0]    nval;
      logic           clip;
      logic           bval;
      logic [23:0]    line;
      logic           last;
   } lex_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jbt_req_if req_if ();
   jbt_rsp_if rsp_if ();

   json_byte_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted results waiting for delivery, and those of the current word.
   lex_result_type expected_results[$];
   lex_result_type step_results[$];

   // Predictor state.
   lex_mode_type lx_mode;
   logic [23:0]  line_no;
   int unsigned  text_cnt;
   logic [31:0]  magnitude_acc;
   logic         neg_sign;
   logic         clip_flag;
   logic [2:0]   kw_alive;
   int unsigned  kw_pos;
   string        kw_spell[3] = '{"true", "false", "null"};

   // Run bookkeeping.
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned words_sent     = 0;
   int unsigned results_checked = 0;
   int unsigned tokens_checked  = 0;
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;
   lex_result_type want_word;

   logic [7:0] blank_set[6] = '{CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_VTAB,
                                CHAR_FFEED, CHAR_CR};
   logic [7:0] punct_set[6] = '{CHAR_LBRACKET, CHAR_RBRACKET, CHAR_LBRACE,
                                CHAR_RBRACE, CHAR_COLON, CHAR_COMMA};
   logic [7:0] delim_set[8] = '{CHAR_SPACE, CHAR_COMMA, CHAR_RBRACKET, CHAR_RBRACE,
                                CHAR_COLON, CHAR_NEWLINE, CHAR_TAB, CHAR_LBRACKET};

   // ------------------------------------------------------------------------
   // Lexer predictor
   // ------------------------------------------------------------------------

   function automatic bit blank_byte(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic bit digit_byte(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] b);
      case (b)
         CHAR_LBRACKET: return TOK_LBRACKET;
         CHAR_RBRACKET: return TOK_RBRACKET;
         CHAR_LBRACE:   return TOK_LBRACE;
         CHAR_RBRACE:   return TOK_RBRACE;
         CHAR_COLON:    return TOK_COLON;
         CHAR_COMMA:    return TOK_COMMA;
         default:       return TOK_UNKNOWN;
      endcase
   endfunction

   function automatic void lexer_reset();
      lx_mode       = MODE_IDLE;
      line_no       = 24'd1;
      text_cnt      = 0;
      magnitude_acc = 32'd0;
      neg_sign      = 1'b0;
      clip_flag     = 1'b0;
      kw_alive      = 3'b111;
      kw_pos        = 0;
   endfunction

   function automatic void emit(input logic kind, input token_kind_type t,
                                input logic [7:0] b, input int unsigned len,
                                input logic [31:0] v, input logic c, input logic bv);
      lex_result_type r;
      r.kind  = kind;
      r.ttype = t;
      r.tbyte = b;
      r.tlen  = len[5:0];
      r.nval  = v;
      r.clip  = c;
      r.bval  = bv;
      r.line  = line_no;
      r.last  = 1'b0;
      step_results.push_back(r);
   endfunction

   // Text bytes past the cap are consumed silently.
   function automatic void store_text(input token_kind_type t, input logic [7:0] b);
      if (text_cnt < TEXT_CAP) begin
         text_cnt++;
         emit(KIND_TEXT, t, b, 0, 32'd0, 1'b0, 1'b0);
      end
   endfunction

   // Decimal accumulation that sticks at the signed limit once passed.
   function automatic void accumulate_digit(input logic [7:0] b);
      logic [63:0] bound;
      logic [63:0] sum;
      if (clip_flag) return;
      bound = neg_sign ? 64'd2147483648 : 64'd2147483647;
      sum   = {32'd0, magnitude_acc} * 64'd10 + {56'd0, b - CHAR_ZERO};
      if (sum > bound) begin
         clip_flag = 1'b1;
         sum       = bound;
      end
      magnitude_acc = sum[31:0];
   endfunction

   function automatic void track_keyword(input logic [7:0] b);
      for (int k = 0; k < 3; k++) begin
         if (kw_alive[k] && (kw_pos >= kw_spell[k].len() || kw_spell[k][kw_pos] != b))
            kw_alive[k] = 1'b0;
      end
      if (kw_pos < 7) kw_pos++;
   endfunction

   function automatic void close_number();
      if (neg_sign && text_cnt == 1)
         emit(KIND_TOKEN, TOK_UNKNOWN, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
      else
         emit(KIND_TOKEN, TOK_NUMBER, 8'h00, text_cnt,
              neg_sign ? (32'd0 - magnitude_acc) : magnitude_acc, clip_flag, 1'b0);
   endfunction

   function automatic void close_word();
      if (kw_alive[0] && kw_pos == 4)
         emit(KIND_TOKEN, TOK_BOOLEAN, 8'h00, text_cnt, 32'd0, 1'b0, 1'b1);
      else if (kw_alive[1] && kw_pos == 5)
         emit(KIND_TOKEN, TOK_BOOLEAN, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
      else if (kw_alive[2] && kw_pos == 4)
         emit(KIND_TOKEN, TOK_NULL, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
      else
         emit(KIND_TOKEN, TOK_UNKNOWN, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
   endfunction

   // A byte seen with no token open.
   function automatic void between_tokens(input logic [7:0] b);
      token_kind_type pk;
      pk = punct_kind(b);
      if (blank_byte(b)) begin
         if (b == CHAR_NEWLINE && line_no != LINE_TOP) line_no++;
      end else if (pk != TOK_UNKNOWN) begin
         emit(KIND_TOKEN, pk, b, 1, 32'd0, 1'b0, 1'b0);
      end else begin
         text_cnt = 0;
         if (b == CHAR_MINUS || digit_byte(b)) begin
            lx_mode       = MODE_NUMBER;
            magnitude_acc = 32'd0;
            clip_flag     = 1'b0;
            neg_sign      = (b == CHAR_MINUS);
            if (!neg_sign) accumulate_digit(b);
            store_text(TOK_NUMBER, b);
         end else if (b == CHAR_QUOTE) begin
            lx_mode = MODE_STRING;
         end else begin
            lx_mode  = MODE_WORD;
            kw_alive = 3'b111;
            kw_pos   = 0;
            track_keyword(b);
            store_text(TOK_UNKNOWN, b);
         end
      end
   endfunction

   // Predicts all result words of one accepted input word.
   function automatic void predict_word(input logic [7:0] b, input logic eoi);
      bit             handled;
      lex_result_type r;
      handled = 1'b0;
      step_results.delete();
      case (lx_mode)
         MODE_HALTED: handled = 1'b1;
         MODE_NUMBER: begin
            if (!eoi && digit_byte(b)) begin
               accumulate_digit(b);
               store_text(TOK_NUMBER, b);
               handled = 1'b1;
            end else begin
               close_number();
               lx_mode = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (!eoi && !blank_byte(b) && punct_kind(b) == TOK_UNKNOWN) begin
               track_keyword(b);
               store_text(TOK_UNKNOWN, b);
               handled = 1'b1;
            end else begin
               close_word();
               lx_mode = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (eoi) begin
               emit(KIND_TOKEN, TOK_UNTERMINATED, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
               lx_mode = MODE_HALTED;
               handled = 1'b1;
            end else if (b == CHAR_QUOTE) begin
               emit(KIND_TOKEN, TOK_STRING, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
               lx_mode = MODE_IDLE;
               handled = 1'b1;
            end else if (b != CHAR_NEWLINE) begin
               store_text(TOK_STRING, b);
               handled = 1'b1;
            end else begin
               // A newline closes the string and is then counted.
               emit(KIND_TOKEN, TOK_STRING, 8'h00, text_cnt, 32'd0, 1'b0, 1'b0);
               lx_mode = MODE_IDLE;
            end
         end
         default: ;
      endcase
      if (!handled) begin
         if (eoi) emit(KIND_TOKEN, TOK_END, 8'h00, 0, 32'd0, 1'b0, 1'b0);
         else     between_tokens(b);
      end
      for (int i = 0; i < step_results.size(); i++) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         expected_results.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                  cycle_count, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   // Each delivered result word is held against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            report_mismatch("result word with nothing expected",
                            32'(rsp_if.token_type), 0);
         end else begin
            want_word = expected_results.pop_front();
            if (want_word.kind == KIND_TOKEN) tokens_checked++;
            check_field("result_kind", 32'(rsp_if.result_kind), 32'(want_word.kind));
            check_field("token_type", 32'(rsp_if.token_type), 32'(want_word.ttype));
            check_field("text_byte", 32'(rsp_if.text_byte), 32'(want_word.tbyte));
            check_field("text_length", 32'(rsp_if.text_length), 32'(want_word.tlen));
            check_field("number_value", rsp_if.number_value, want_word.nval);
            check_field("number_clipped", 32'(rsp_if.number_clipped),
                        32'(want_word.clip));
            check_field("bool_value", 32'(rsp_if.bool_value), 32'(want_word.bval));
            check_field("line_number", 32'(rsp_if.line_number), 32'(want_word.line));
            check_field("last", 32'(rsp_if.last), 32'(want_word.last));
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Sends one word; entered and left at a falling edge.
   task automatic send_word(input logic [7:0] b, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= b;
      req_if.end_of_input <= eoi;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_word(b, eoi);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
   endtask

   // Holds the sender until every predicted result has been delivered.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_delimiter();
      send_word(delim_set[$urandom_range(0, 7)], 1'b0);
   endtask

   function automatic string digit_run(input int unsigned n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      return s;
   endfunction

   // One random token, mostly well-formed, with some noise mixed in.
   task automatic send_random_token();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  c;
      string       s;
      string       kw;
      longint      edge_vals[6];
      edge_vals = '{64'd2147483646, 64'd2147483647, 64'd2147483648,
                    64'd2147483649, 64'd4294967296, 64'd99999999999};
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         send_word(punct_set[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 24) begin
         n = $urandom_range(1, 3);
         repeat (n) send_word(blank_set[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 46) begin
         // Numbers: short, at the 32-bit edges, or long runs that can pass the text cap.
         if ($urandom_range(0, 9) == 0) begin
            s = "-";
         end else begin
            case ($urandom_range(0, 9))
               0:       s = $sformatf("%0d", edge_vals[$urandom_range(0, 5)]);
               1:       s = digit_run($urandom_range(11, 70));
               default: s = digit_run($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 9) < 3) s = {"-", s};
         end
         send_text(s);
         send_delimiter();
      end else if (pick < 66) begin
         // Strings with arbitrary content, closed by a quote or a newline.
         n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 8);
         send_word(CHAR_QUOTE, 1'b0);
         repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_QUOTE || c == CHAR_NEWLINE) c = 8'h41;
            send_word(c, 1'b0);
         end
         send_word(($urandom_range(0, 99) < 85) ? CHAR_QUOTE : CHAR_NEWLINE, 1'b0);
      end else if (pick < 82) begin
         // Keywords, near misses and other bare words.
         kw = kw_spell[$urandom_range(0, 2)];
         case ($urandom_range(0, 4))
            0, 1: s = kw;
            2:    s = kw.substr(0, kw.len() - 2);
            3:    s = {kw, "s"};
            default: begin
               s = "";
               n = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 5);
               repeat (n) begin
                  c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h21, 8'hFF))
                                                 : 8'($urandom_range(8'h61, 8'h7A));
                  if (punct_kind(c) != TOK_UNKNOWN) c = 8'h7A;
                  s = {s, string'(c)};
               end
            end
         endcase
         send_text(s);
         send_delimiter();
      end else if (pick < 96) begin
         send_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         // End of input, kept out of open strings until the final test.
         if (lx_mode == MODE_STRING) send_word(CHAR_QUOTE, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Punctuation, every blank, a lone minus, a number ended by a quote, a
   // string ended by a newline, end of input between tokens twice, and a
   // keyword ended by end of input.
   task automatic test_directed();
      foreach (punct_set[i]) send_word(punct_set[i], 1'b0);
      foreach (blank_set[i]) send_word(blank_set[i], 1'b0);
      send_text("-]42\"a\n");
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      send_text("false");
      send_word(8'h5A, 1'b1);
      drain_results();
   endtask

   // Random token stream under each flow-control phase.
   task automatic test_random_stream();
      int idle_pcts[4];
      int stall_pcts[4];
      int unsigned stop_at;
      idle_pcts  = '{0, 82, 0, 17};
      stall_pcts = '{0, 0, 82, 17};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_pcts[p];
         recv_stall_pct = stall_pcts[p];
         stop_at        = words_sent + PHASE_WORDS;
         while (words_sent < stop_at) begin
            send_random_token();
            if (p[0] && words_sent >= stop_at - PHASE_WORDS / 2 &&
                words_sent < stop_at - PHASE_WORDS / 2 + 8)
               drain_results();
         end
      end
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // End of input inside a string halts the block; later words are ignored.
   task automatic test_unterminated();
      send_word(CHAR_NEWLINE, 1'b0);
      send_text("\"ab");
      send_word(8'h22, 1'b1);
      send_text("[1 x");
      send_word(8'h00, 1'b1);
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.data_byte    = 8'h00;
      req_if.end_of_input = 1'b0;
      rsp_if.ready        = 1'b0;
      lexer_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_stream();
      test_unterminated();
      drain_results();

      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), 0);
      $display("Sent %0d input words over four flow-control phases, ending in a halt.",
               words_sent);
      $display("Checked %0d result words, %0d of them completed tokens; %0d mismatches.",
               results_checked, tokens_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
